/* hdl/ddqtm_pkg.sv */
// shared types and constants for the differential drive quick-turn mixer
// no dependencies; imported by the controller, datapath and top level
package ddqtm_pkg;

    localparam int FIELD_W = 16;
    localparam int DRIVE_W = 18;
    localparam int LEVEL_W = 18;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WHEEL_DEADBAND    = 3'd0;
    localparam logic [IDX_W-1:0] REG_THROTTLE_DEADBAND = 3'd1;
    localparam logic [IDX_W-1:0] REG_TURN_SENSITIVITY  = 3'd2;
    localparam logic [IDX_W-1:0] REG_QS_THROTTLE_LIMIT = 3'd3;
    localparam logic [IDX_W-1:0] REG_QS_ALPHA          = 3'd4;

    localparam logic [14:0] RST_WHEEL_DEADBAND    = 15'd328;
    localparam logic [14:0] RST_THROTTLE_DEADBAND = 15'd328;
    localparam logic [15:0] RST_TURN_SENSITIVITY  = 16'd26214;
    localparam logic [14:0] RST_QS_THROTTLE_LIMIT = 15'd3277;
    localparam logic [14:0] RST_QS_ALPHA          = 15'd1638;

    localparam int ONE_Q14   = 16384;
    localparam int DRIVE_MAX = 81920;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic finish;
    } ddqtm_cmd_t;

endpackage

/* hdl/ddqtm_ctrl.sv */
// sequencer for the mixer: capture, two multiplier passes, finish
// depends on ddqtm_pkg; drives the datapath through ddqtm_cmd_t
module ddqtm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ddqtm_pkg::ddqtm_cmd_t cmd
);
    import ddqtm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && in_valid;
        cmd.mul1   = (state_reg == S_MUL1);
        cmd.mul2   = (state_reg == S_MUL2);
        cmd.finish = (state_reg == S_FIN) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_MUL1;
            end
            S_MUL1:
                state_next = S_MUL2;
            S_MUL2:
                state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hdl/ddqtm_dp.sv */
// datapath: config registers, deadband, shared 32x17 multiplier,
// accumulator, mixing and clipping; depends on ddqtm_pkg
module ddqtm_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ddqtm_pkg::ddqtm_cmd_t              cmd,
    input  logic                               cfg_we,
    input  logic [ddqtm_pkg::IDX_W-1:0]        cfg_index,
    input  logic [ddqtm_pkg::CFG_W-1:0]        cfg_data,
    input  logic signed [ddqtm_pkg::FIELD_W-1:0] throttle,
    input  logic signed [ddqtm_pkg::FIELD_W-1:0] wheel,
    input  logic                               quick_turn,
    output logic signed [ddqtm_pkg::DRIVE_W-1:0] left_drive,
    output logic signed [ddqtm_pkg::DRIVE_W-1:0] right_drive
);
    import ddqtm_pkg::*;

    localparam logic [14:0]        ONE15   = 15'(ONE_Q14);
    localparam logic signed [15:0] ONE16   = 16'(ONE_Q14);
    localparam logic signed [21:0] ONE22   = 22'(ONE_Q14);
    localparam logic signed [21:0] DMAX22  = 22'(DRIVE_MAX);
    localparam logic signed [48:0] RND14   = 49'sd8192;
    localparam logic signed [48:0] RND28   = 49'sd134217728;
    localparam logic signed [48:0] LMAX49  = 49'sd131071;
    localparam logic signed [48:0] LMIN49  = -49'sd131072;
    localparam logic signed [17:0] ONE18   = 18'(ONE_Q14);

    logic [14:0] wheel_db_reg, thr_db_reg, qs_limit_reg, qs_alpha_reg;
    logic [15:0] sens_reg;

    logic signed [15:0] thr_reg, whl_reg;
    logic               quick_reg, upd_reg;
    logic signed [48:0] prod_reg;
    logic signed [LEVEL_W-1:0] level_reg, level_next;
    logic signed [DRIVE_W-1:0] left_reg, right_reg;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        begin
            e = 17'(v);
            abs16 = v[15] ? 17'(-e) : 17'(e);
        end
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_db_reg <= RST_WHEEL_DEADBAND;
            thr_db_reg   <= RST_THROTTLE_DEADBAND;
            sens_reg     <= RST_TURN_SENSITIVITY;
            qs_limit_reg <= RST_QS_THROTTLE_LIMIT;
            qs_alpha_reg <= RST_QS_ALPHA;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WHEEL_DEADBAND:    wheel_db_reg <= cfg_data[14:0];
                REG_THROTTLE_DEADBAND: thr_db_reg   <= cfg_data[14:0];
                REG_TURN_SENSITIVITY:  sens_reg     <= cfg_data;
                REG_QS_THROTTLE_LIMIT: qs_limit_reg <= cfg_data[14:0];
                REG_QS_ALPHA:          qs_alpha_reg <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // deadband at capture
    logic [16:0]        thr_abs_in, whl_abs_in, thr_abs_db;
    logic signed [15:0] thr_in_db, whl_in_db;

    always_comb
    begin
        thr_abs_in = abs16(throttle);
        whl_abs_in = abs16(wheel);
        thr_in_db  = (thr_abs_in > {2'b00, thr_db_reg}) ? throttle : '0;
        whl_in_db  = (whl_abs_in > {2'b00, wheel_db_reg}) ? wheel : '0;
        thr_abs_db = (thr_abs_in > {2'b00, thr_db_reg}) ? thr_abs_in : '0;
    end

    // multiplier operands
    logic [14:0]        alpha_sat, one_minus;
    logic signed [15:0] whl_cl;
    logic signed [16:0] target;
    logic signed [31:0] op_a;
    logic signed [16:0] op_b;
    logic signed [48:0] mul_w;

    always_comb
    begin
        alpha_sat = (qs_alpha_reg > ONE15) ? ONE15 : qs_alpha_reg;
        one_minus = ONE15 - alpha_sat;
        if (whl_reg > ONE16)
            whl_cl = ONE16;
        else if (whl_reg < -ONE16)
            whl_cl = -ONE16;
        else
            whl_cl = whl_reg;
        target = {whl_cl, 1'b0};
        if (cmd.mul2)
        begin
            if (quick_reg)
            begin
                op_a = 32'(target);
                op_b = {2'b00, alpha_sat};
            end
            else
            begin
                op_a = prod_reg[31:0];
                op_b = {1'b0, sens_reg};
            end
        end
        else
        begin
            if (quick_reg)
            begin
                op_a = 32'(level_reg);
                op_b = {2'b00, one_minus};
            end
            else
            begin
                op_a = 32'(whl_reg);
                op_b = abs16(thr_reg);
            end
        end
    end

    assign mul_w = op_a * op_b;

    // finish: rounding, turn, mixing, clipping
    logic signed [48:0] q_sum, q_sh, n_sum, n_sh;
    logic signed [LEVEL_W-1:0] lvl_q;
    logic signed [21:0] ang, lsum, rsum, lcl, rcl;
    logic signed [DRIVE_W-1:0] left_fin, right_fin;

    always_comb
    begin
        q_sum = prod_reg + RND14;
        q_sh  = q_sum >>> 14;
        n_sum = prod_reg + RND28;
        n_sh  = n_sum >>> 28;
        if (q_sh > LMAX49)
            lvl_q = LEVEL_W'(LMAX49);
        else if (q_sh < LMIN49)
            lvl_q = LEVEL_W'(LMIN49);
        else
            lvl_q = q_sh[LEVEL_W-1:0];

        if (quick_reg)
            ang = 22'(whl_reg);
        else
            ang = 22'(n_sh) - 22'(level_reg);

        lsum = 22'(thr_reg) + ang;
        rsum = 22'(thr_reg) - ang;
        lcl  = lsum;
        rcl  = rsum;
        // only the first side out of range is clipped
        priority if (lsum > ONE22)
        begin
            if (quick_reg)
                rcl = rsum - (lsum - ONE22);
            lcl = ONE22;
        end
        else if (rsum > ONE22)
        begin
            if (quick_reg)
                lcl = lsum - (rsum - ONE22);
            rcl = ONE22;
        end
        else if (lsum < -ONE22)
        begin
            if (quick_reg)
                rcl = rsum + (-ONE22 - lsum);
            lcl = -ONE22;
        end
        else if (rsum < -ONE22)
        begin
            if (quick_reg)
                lcl = lsum + (-ONE22 - rsum);
            rcl = -ONE22;
        end

        if (lcl > DMAX22)
            left_fin = DRIVE_W'(DMAX22);
        else if (lcl < -DMAX22)
            left_fin = DRIVE_W'(-DMAX22);
        else
            left_fin = lcl[DRIVE_W-1:0];
        if (rcl > DMAX22)
            right_fin = DRIVE_W'(DMAX22);
        else if (rcl < -DMAX22)
            right_fin = DRIVE_W'(-DMAX22);
        else
            right_fin = rcl[DRIVE_W-1:0];

        if (quick_reg)
            level_next = upd_reg ? lvl_q : level_reg;
        else if (level_reg > ONE18)
            level_next = level_reg - ONE18;
        else if (level_reg < -ONE18)
            level_next = level_reg + ONE18;
        else
            level_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (cmd.finish)
            level_reg <= level_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            thr_reg   <= thr_in_db;
            whl_reg   <= whl_in_db;
            quick_reg <= quick_turn;
            upd_reg   <= (thr_abs_db < {2'b00, qs_limit_reg});
        end
        if (cmd.mul1)
            prod_reg <= mul_w;
        else if (cmd.mul2)
            prod_reg <= quick_reg ? prod_reg + mul_w : mul_w;
        if (cmd.finish)
        begin
            left_reg  <= left_fin;
            right_reg <= right_fin;
        end
    end

    assign left_drive  = left_reg;
    assign right_drive = right_reg;

endmodule

/* hdl/differential_drive_quick_turn_mixer_unit.sv */
// top level of the differential drive quick-turn mixer
// depends on ddqtm_pkg, ddqtm_ctrl and ddqtm_dp

// Joystick mixer: each transfer of throttle, wheel and quick_turn (signed
// Q1.14) yields one transfer of left_drive and right_drive (signed Q3.14,
// within +-5.0). A sample goes through capture, two multiplier passes and a
// finish step that loads its result into the output register: the transfer
// cycle captures and applies the deadbands, two passes go through the one
// shared 32x17 multiplier (the turn product in normal mode, the accumulator
// blend in quick-turn mode), and the finish step rounds, mixes and clips.
// With the output free, the next sample transfers in the cycle after the
// finish step; only one sample is in work at a time. The next sample is
// taken while a result waits in the output register; the finish step holds
// while that register is still full and stalled. in_stall is high from the
// first multiplier pass until the finish step completes.
// The quick-stop accumulator clears on reset; no clearing pass is needed.
// Configuration writes are meant for times when no sample is in flight.
module differential_drive_quick_turn_mixer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ddqtm_pkg::IDX_W-1:0]          cfg_index,
    input  logic [ddqtm_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ddqtm_pkg::FIELD_W-1:0] throttle,
    input  logic signed [ddqtm_pkg::FIELD_W-1:0] wheel,
    input  logic                                 quick_turn,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [ddqtm_pkg::DRIVE_W-1:0] left_drive,
    output logic signed [ddqtm_pkg::DRIVE_W-1:0] right_drive
);
    import ddqtm_pkg::*;

    localparam logic signed [DRIVE_W-1:0] DMAX = DRIVE_W'(DRIVE_MAX);

    ddqtm_cmd_t cmd;

    ddqtm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    ddqtm_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .throttle    (throttle),
        .wheel       (wheel),
        .quick_turn  (quick_turn),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

    // a captured sample keeps the input side closed for the whole sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input taken while a sample is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive <= DMAX) && (left_drive >= -DMAX))
    else $error("left drive out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (right_drive <= DMAX) && (right_drive >= -DMAX))
    else $error("right drive out of range");

    // a new result appears only at the end of a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result without a sample in work");

endmodule
